// File: hdl/zcd_pkg.sv
// Package for the zip central directory parser.
// Holds widths, header offsets, result kinds and the word structs.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package zcd_pkg;

    localparam int unsigned MAX_DIR_BYTES = 32768;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned POS_W    = 18;
    localparam int unsigned DIRPOS_W = 17;
    localparam int unsigned LANE_W   = 2;

    localparam int unsigned HDR_LEN     = 46;
    localparam int unsigned POS_METHOD  = 10;
    localparam int unsigned POS_CRC     = 16;
    localparam int unsigned POS_CSIZE   = 20;
    localparam int unsigned POS_USIZE   = 24;
    localparam int unsigned POS_NAMELEN = 28;
    localparam int unsigned POS_EXTLEN  = 30;
    localparam int unsigned POS_CMTLEN  = 32;
    localparam int unsigned POS_OFFSET  = 42;
    localparam int unsigned METHOD_MAX  = 255;

    typedef enum logic [1:0] {
        KIND_NAME_BYTE = 2'd0,
        KIND_ENTRY     = 2'd1,
        KIND_TOO_BIG   = 2'd2,
        KIND_TRUNCATED = 2'd3
    } kind_t;

    typedef enum logic [0:0] {
        REG_ENTRY_COUNT    = 1'b0,
        REG_DIRECTORY_SIZE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] dir_byte;
        logic              first_byte;
    } in_word_t;

    typedef struct packed {
        kind_t              kind;
        logic [COUNT_W-1:0] entry_index;
        logic [BYTE_W-1:0]  name_char;
        logic [COUNT_W-1:0] name_pos;
        logic [BYTE_W-1:0]  method;
        logic [WORD_W-1:0]  crc;
        logic [WORD_W-1:0]  comp_size;
        logic [WORD_W-1:0]  uncomp_size;
        logic [WORD_W-1:0]  local_offset;
        logic [COUNT_W-1:0] name_len;
        logic               last_entry;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic [WORD_W-1:0]  directory_size;
    } cfg_t;

endpackage
`default_nettype wire

// File: hdl/zcd_in_if.sv
// Input byte channel of the zip central directory parser.
// Depends on zcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface zcd_in_if;
    logic                      valid;
    logic                      ready;
    logic [zcd_pkg::BYTE_W-1:0] dir_byte;
    logic                      first_byte;

    modport source (output valid, output dir_byte, output first_byte, input ready);
    modport sink (input valid, input dir_byte, input first_byte, output ready);
endinterface
`default_nettype wire

// File: hdl/zcd_out_if.sv
// Result channel of the zip central directory parser.
// Depends on zcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface zcd_out_if;
    logic                        valid;
    logic                        ready;
    zcd_pkg::kind_t              kind;
    logic [zcd_pkg::COUNT_W-1:0] entry_index;
    logic [zcd_pkg::BYTE_W-1:0]  name_char;
    logic [zcd_pkg::COUNT_W-1:0] name_pos;
    logic [zcd_pkg::BYTE_W-1:0]  method;
    logic [zcd_pkg::WORD_W-1:0]  crc;
    logic [zcd_pkg::WORD_W-1:0]  comp_size;
    logic [zcd_pkg::WORD_W-1:0]  uncomp_size;
    logic [zcd_pkg::WORD_W-1:0]  local_offset;
    logic [zcd_pkg::COUNT_W-1:0] name_len;
    logic                        last_entry;

    modport source (
        output valid, output kind, output entry_index, output name_char,
        output name_pos, output method, output crc, output comp_size,
        output uncomp_size, output local_offset, output name_len,
        output last_entry, input ready
    );
    modport sink (
        input valid, input kind, input entry_index, input name_char,
        input name_pos, input method, input crc, input comp_size,
        input uncomp_size, input local_offset, input name_len,
        input last_entry, output ready
    );
endinterface
`default_nettype wire

// File: hdl/zcd_cfg_if.sv
// Configuration write channel of the zip central directory parser.
// Depends on zcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface zcd_cfg_if;
    logic                       valid;
    logic                       ready;
    zcd_pkg::cfg_index_t        index;
    logic [zcd_pkg::WORD_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/zip_central_directory_parser.sv
// Top level of the zip central directory parser.
// Depends on zcd_pkg, the channel interfaces, zcd_cfg_regs, zcd_in_stage,
// zcd_parse_core and zcd_out_stage.
//
// Channel  Modport  Word
// dir      sink     dir_byte, first_byte
// result   source   kind, entry_index, name fields, entry fields, last_entry
// cfg      sink     index, data (entry_count, directory_size)
//
// Each byte is parsed combinationally between the input register and the
// result register, so one word is taken per cycle unless the result channel
// stalls, and a result is registered as its byte leaves the input register.
// A stall on the result channel holds the result register, then the input
// register, and then drops dir.ready. Reset leaves the parser stopped until a
// byte with first_byte set arrives. Configuration writes are taken every cycle.
`timescale 1ns / 1ps
`default_nettype none
module zip_central_directory_parser (
    input  wire logic clk,
    input  wire logic rst_n,
    zcd_in_if.sink    dir,
    zcd_out_if.source result,
    zcd_cfg_if.sink   cfg
);
    import zcd_pkg::*;

    cfg_t     cfg_word;
    in_word_t in_word;
    result_t  res_word;
    logic     word_valid;
    logic     take;
    logic     space;
    logic     res_valid;

    zcd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_word)
    );

    zcd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .dir        (dir),
        .take       (take),
        .word_valid (word_valid),
        .word       (in_word)
    );

    zcd_parse_core u_parse_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word       (in_word),
        .cfg        (cfg_word),
        .space      (space),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res_word)
    );

    zcd_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (take && res_valid),
        .res    (res_word),
        .space  (space),
        .result (result)
    );

endmodule
`default_nettype wire

// File: hdl/zcd_cfg_regs.sv
// Configuration registers: entry count and directory size.
// Depends on zcd_pkg and zcd_cfg_if.
`timescale 1ns / 1ps
`default_nettype none
module zcd_cfg_regs (
    input  wire logic    clk,
    input  wire logic    rst_n,
    zcd_cfg_if.sink      cfg,
    output zcd_pkg::cfg_t cfg_out
);
    import zcd_pkg::*;

    logic [COUNT_W-1:0] entry_count_reg;
    logic [COUNT_W-1:0] entry_count_next;
    logic [WORD_W-1:0]  directory_size_reg;
    logic [WORD_W-1:0]  directory_size_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        entry_count_next    = entry_count_reg;
        directory_size_next = directory_size_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_ENTRY_COUNT:    entry_count_next = cfg.data[COUNT_W-1:0];
                REG_DIRECTORY_SIZE: directory_size_next = cfg.data;
                default:            entry_count_next = entry_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg    <= '0;
            directory_size_reg <= '0;
        end
        else
        begin
            entry_count_reg    <= entry_count_next;
            directory_size_reg <= directory_size_next;
        end
    end

    assign cfg_out.entry_count    = entry_count_reg;
    assign cfg_out.directory_size = directory_size_reg;

endmodule
`default_nettype wire

// File: hdl/zcd_in_stage.sv
// Input register for directory bytes.
// Depends on zcd_pkg and zcd_in_if.
`timescale 1ns / 1ps
`default_nettype none
module zcd_in_stage (
    input  wire logic        clk,
    input  wire logic        rst_n,
    zcd_in_if.sink           dir,
    input  wire logic        take,
    output logic             word_valid,
    output zcd_pkg::in_word_t word
);
    import zcd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     load;

    assign dir.ready = !valid_reg || take;
    assign load      = dir.valid && dir.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg.dir_byte   <= dir.dir_byte;
            word_reg.first_byte <= dir.first_byte;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule
`default_nettype wire

// File: hdl/zcd_parse_core.sv
// Record parser state and the per-byte update logic.
// Depends on zcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module zcd_parse_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             word_valid,
    input  wire zcd_pkg::in_word_t word,
    input  wire zcd_pkg::cfg_t    cfg,
    input  wire logic             space,
    output logic                  take,
    output logic                  res_valid,
    output zcd_pkg::result_t      res
);
    import zcd_pkg::*;

    logic [POS_W-1:0]    record_pos_reg, record_pos_next;
    logic [DIRPOS_W-1:0] dir_pos_reg, dir_pos_next;
    logic [POS_W-1:0]    record_end_reg, record_end_next;
    logic [COUNT_W-1:0]  entries_left_reg, entries_left_next;
    logic [COUNT_W-1:0]  entry_number_reg, entry_number_next;
    logic [WORD_W-1:0]   crc_reg, crc_next;
    logic [WORD_W-1:0]   csize_reg, csize_next;
    logic [WORD_W-1:0]   usize_reg, usize_next;
    logic [WORD_W-1:0]   offset_reg, offset_next;
    logic [COUNT_W-1:0]  method_reg, method_next;
    logic [COUNT_W-1:0]  name_len_reg, name_len_next;
    logic [COUNT_W-1:0]  extra_len_reg, extra_len_next;
    logic [COUNT_W-1:0]  comment_len_reg, comment_len_next;
    logic                stopped_reg, stopped_next;

    logic               active;
    logic [POS_W-1:0]   p;
    logic [POS_W:0]     p_plus;
    logic [LANE_W-1:0]  lane;
    logic [POS_W-1:0]   rec_len;
    logic [WORD_W:0]    rec_limit;
    logic [POS_W-1:0]   name_end;
    logic [BYTE_W-1:0]  b;

    assign take = word_valid && space;

    always_comb
    begin
        record_pos_next   = record_pos_reg;
        dir_pos_next      = dir_pos_reg;
        record_end_next   = record_end_reg;
        entries_left_next = entries_left_reg;
        entry_number_next = entry_number_reg;
        crc_next          = crc_reg;
        csize_next        = csize_reg;
        usize_next        = usize_reg;
        offset_next       = offset_reg;
        method_next       = method_reg;
        name_len_next     = name_len_reg;
        extra_len_next    = extra_len_reg;
        comment_len_next  = comment_len_reg;
        stopped_next      = stopped_reg;
        res_valid         = 1'b0;
        res               = '0;
        active            = 1'b0;
        b                 = word.dir_byte;
        lane              = '0;
        rec_len           = '0;
        rec_limit         = '0;
        name_end          = '0;
        p                 = '0;
        p_plus            = '0;

        if (word.first_byte)
        begin
            dir_pos_next      = '0;
            entries_left_next = cfg.entry_count;
            entry_number_next = '0;
            record_pos_next   = '0;
            record_end_next   = '0;
            crc_next          = '0;
            csize_next        = '0;
            usize_next        = '0;
            offset_next       = '0;
            method_next       = '0;
            name_len_next     = '0;
            extra_len_next    = '0;
            comment_len_next  = '0;
            stopped_next      = 1'b0;
            if (cfg.directory_size > WORD_W'(MAX_DIR_BYTES))
            begin
                stopped_next = 1'b1;
                res_valid    = 1'b1;
                res.kind     = KIND_TOO_BIG;
            end
            else if (cfg.entry_count == '0)
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                active = 1'b1;
            end
        end
        else if (!stopped_reg)
        begin
            active = 1'b1;
        end

        if (active)
        begin
            p = record_pos_next;
            if (p inside {[POS_METHOD:POS_METHOD+1]})
            begin
                method_next[{p[0], 3'b000} +: BYTE_W] = b;
            end
            else if (p inside {[POS_CRC:POS_CRC+3]})
            begin
                crc_next[{p[1:0], 3'b000} +: BYTE_W] = b;
            end
            else if (p inside {[POS_CSIZE:POS_CSIZE+3]})
            begin
                csize_next[{p[1:0], 3'b000} +: BYTE_W] = b;
            end
            else if (p inside {[POS_USIZE:POS_USIZE+3]})
            begin
                usize_next[{p[1:0], 3'b000} +: BYTE_W] = b;
            end
            else if (p inside {[POS_NAMELEN:POS_NAMELEN+1]})
            begin
                name_len_next[{p[0], 3'b000} +: BYTE_W] = b;
            end
            else if (p inside {[POS_EXTLEN:POS_EXTLEN+1]})
            begin
                extra_len_next[{p[0], 3'b000} +: BYTE_W] = b;
            end
            else if (p inside {[POS_CMTLEN:POS_CMTLEN+1]})
            begin
                comment_len_next[{p[0], 3'b000} +: BYTE_W] = b;
            end
            else if (p inside {[POS_OFFSET:POS_OFFSET+3]})
            begin
                lane = LANE_W'(p - POS_W'(POS_OFFSET));
                offset_next[{lane, 3'b000} +: BYTE_W] = b;
            end

            if (p == POS_W'(POS_CMTLEN + 1))
            begin
                rec_len = POS_W'(HDR_LEN) + POS_W'(name_len_next)
                        + POS_W'(extra_len_next) + POS_W'(comment_len_next);
                record_end_next = rec_len;
                rec_limit = (WORD_W+1)'(dir_pos_next) + (WORD_W+1)'(rec_len);
                if (rec_limit > (WORD_W+1)'(cfg.directory_size))
                begin
                    stopped_next    = 1'b1;
                    res_valid       = 1'b1;
                    res.kind        = KIND_TRUNCATED;
                    res.entry_index = entry_number_next;
                end
            end

            if (!(res_valid && res.kind == KIND_TRUNCATED))
            begin
                name_end = POS_W'(HDR_LEN) + POS_W'(name_len_next);
                if (p == POS_W'(HDR_LEN - 1))
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_ENTRY;
                    res.entry_index  = entry_number_next;
                    res.method       = (method_next > COUNT_W'(METHOD_MAX))
                                     ? BYTE_W'(METHOD_MAX) : method_next[BYTE_W-1:0];
                    res.crc          = crc_next;
                    res.comp_size    = csize_next;
                    res.uncomp_size  = usize_next;
                    res.local_offset = offset_next;
                    res.name_len     = name_len_next;
                    res.last_entry   = (entries_left_next == COUNT_W'(1));
                end
                else if (p >= POS_W'(HDR_LEN) && p < name_end)
                begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_NAME_BYTE;
                    res.entry_index = entry_number_next;
                    res.name_char   = b;
                    res.name_pos    = COUNT_W'(p - POS_W'(HDR_LEN));
                end

                p_plus = (POS_W+1)'(p) + (POS_W+1)'(1);
                if (p >= POS_W'(HDR_LEN - 1) && p_plus >= (POS_W+1)'(record_end_next))
                begin
                    dir_pos_next      = dir_pos_next + record_end_next[DIRPOS_W-1:0];
                    entries_left_next = entries_left_next - COUNT_W'(1);
                    entry_number_next = entry_number_next + COUNT_W'(1);
                    record_pos_next   = '0;
                    record_end_next   = '0;
                    crc_next          = '0;
                    csize_next        = '0;
                    usize_next        = '0;
                    offset_next       = '0;
                    method_next       = '0;
                    name_len_next     = '0;
                    extra_len_next    = '0;
                    comment_len_next  = '0;
                    if (entries_left_next == '0)
                    begin
                        stopped_next = 1'b1;
                    end
                end
                else
                begin
                    record_pos_next = p_plus[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_pos_reg   <= '0;
            dir_pos_reg      <= '0;
            record_end_reg   <= '0;
            entries_left_reg <= '0;
            entry_number_reg <= '0;
            crc_reg          <= '0;
            csize_reg        <= '0;
            usize_reg        <= '0;
            offset_reg       <= '0;
            method_reg       <= '0;
            name_len_reg     <= '0;
            extra_len_reg    <= '0;
            comment_len_reg  <= '0;
            stopped_reg      <= 1'b1;
        end
        else if (take)
        begin
            record_pos_reg   <= record_pos_next;
            dir_pos_reg      <= dir_pos_next;
            record_end_reg   <= record_end_next;
            entries_left_reg <= entries_left_next;
            entry_number_reg <= entry_number_next;
            crc_reg          <= crc_next;
            csize_reg        <= csize_next;
            usize_reg        <= usize_next;
            offset_reg       <= offset_next;
            method_reg       <= method_next;
            name_len_reg     <= name_len_next;
            extra_len_reg    <= extra_len_next;
            comment_len_reg  <= comment_len_next;
            stopped_reg      <= stopped_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/zcd_out_stage.sv
// Result register that drives the result channel.
// Depends on zcd_pkg and zcd_out_if.
`timescale 1ns / 1ps
`default_nettype none
module zcd_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire zcd_pkg::result_t res,
    output logic                  space,
    zcd_out_if.source             result
);
    import zcd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result.valid        = valid_reg;
    assign result.kind         = res_reg.kind;
    assign result.entry_index  = res_reg.entry_index;
    assign result.name_char    = res_reg.name_char;
    assign result.name_pos     = res_reg.name_pos;
    assign result.method       = res_reg.method;
    assign result.crc          = res_reg.crc;
    assign result.comp_size    = res_reg.comp_size;
    assign result.uncomp_size  = res_reg.uncomp_size;
    assign result.local_offset = res_reg.local_offset;
    assign result.name_len     = res_reg.name_len;
    assign result.last_entry   = res_reg.last_entry;

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for zip_central_directory_parser.
// Streams directories with well-formed and broken records and checks each word against
// a scoreboard that predicts the parser. Depends on zcd_pkg, the channel interfaces and the RTL.
`timescale 1ns / 1ps
module testbench;
    import zcd_pkg::*;

    localparam int ITEM_GOAL    = 1800;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int TIMEOUT_NS   = 20_000_000;

    class zip_dir_scoreboard;
        logic [COUNT_W-1:0]  entry_count;
        logic [WORD_W-1:0]   directory_size;
        logic [POS_W-1:0]    record_pos;
        logic [POS_W-1:0]    record_end;
        logic [DIRPOS_W-1:0] dir_pos;
        logic [COUNT_W-1:0]  entries_left;
        logic [COUNT_W-1:0]  entry_number;
        logic [WORD_W-1:0]   crc_acc;
        logic [WORD_W-1:0]   csize_acc;
        logic [WORD_W-1:0]   usize_acc;
        logic [WORD_W-1:0]   offset_acc;
        logic [COUNT_W-1:0]  method_acc;
        logic [COUNT_W-1:0]  len_acc [3];
        bit                  stopped;
        result_t             due_results [$];
        int                  errors;
        int                  parsed_bytes;

        function new();
            entry_count = '0;
            directory_size = '0;
            dir_pos = '0;
            entries_left = '0;
            entry_number = '0;
            clear_record();
            stopped = 1'b1;
            errors = 0;
            parsed_bytes = 0;
        endfunction

        function void clear_record();
            record_pos = '0;
            record_end = '0;
            crc_acc = '0;
            csize_acc = '0;
            usize_acc = '0;
            offset_acc = '0;
            method_acc = '0;
            len_acc[0] = '0;
            len_acc[1] = '0;
            len_acc[2] = '0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [WORD_W-1:0] value);
            if (idx == REG_ENTRY_COUNT)
                entry_count = value[COUNT_W-1:0];
            else
                directory_size = value;
        endfunction

        function void parse_byte(logic [BYTE_W-1:0] b, logic first);
            result_t     r;
            int unsigned p;
            r = '0;
            parsed_bytes++;
            if (!first && stopped)
                return;
            if (first)
            begin
                dir_pos = '0;
                entries_left = entry_count;
                entry_number = '0;
                clear_record();
                stopped = 1'b0;
                if (directory_size > MAX_DIR_BYTES)
                begin
                    stopped = 1'b1;
                    r.kind = KIND_TOO_BIG;
                    due_results.push_back(r);
                    return;
                end
                if (entries_left == 0)
                begin
                    stopped = 1'b1;
                    return;
                end
            end

            p = record_pos;
            if (p == POS_METHOD || p == POS_METHOD + 1)
                method_acc[(p - POS_METHOD) * 8 +: 8] = b;
            else if (p >= POS_CRC && p < POS_CSIZE)
                crc_acc[(p - POS_CRC) * 8 +: 8] = b;
            else if (p >= POS_CSIZE && p < POS_USIZE)
                csize_acc[(p - POS_CSIZE) * 8 +: 8] = b;
            else if (p >= POS_USIZE && p < POS_NAMELEN)
                usize_acc[(p - POS_USIZE) * 8 +: 8] = b;
            else if (p >= POS_NAMELEN && p < POS_CMTLEN + 2)
                len_acc[(p - POS_NAMELEN) / 2][((p - POS_NAMELEN) % 2) * 8 +: 8] = b;
            else if (p >= POS_OFFSET && p < HDR_LEN)
                offset_acc[(p - POS_OFFSET) * 8 +: 8] = b;

            // The record length is known once the comment length is complete.
            if (p == POS_CMTLEN + 1)
            begin
                record_end = POS_W'(HDR_LEN + len_acc[0] + len_acc[1] + len_acc[2]);
                if (32'(dir_pos) + 32'(record_end) > directory_size)
                begin
                    stopped = 1'b1;
                    r.kind = KIND_TRUNCATED;
                    r.entry_index = entry_number;
                    due_results.push_back(r);
                    return;
                end
            end

            if (p == HDR_LEN - 1)
            begin
                r.kind = KIND_ENTRY;
                r.entry_index = entry_number;
                r.method = (method_acc > METHOD_MAX) ? 8'(METHOD_MAX) : method_acc[7:0];
                r.crc = crc_acc;
                r.comp_size = csize_acc;
                r.uncomp_size = usize_acc;
                r.local_offset = offset_acc;
                r.name_len = len_acc[0];
                r.last_entry = (entries_left == 1);
                due_results.push_back(r);
            end
            else if (p >= HDR_LEN && p < HDR_LEN + len_acc[0])
            begin
                r.kind = KIND_NAME_BYTE;
                r.entry_index = entry_number;
                r.name_char = b;
                r.name_pos = COUNT_W'(p - HDR_LEN);
                due_results.push_back(r);
            end

            if (p >= HDR_LEN - 1 && p + 1 >= record_end)
            begin
                dir_pos = DIRPOS_W'(dir_pos + record_end);
                entries_left = entries_left - 1'b1;
                entry_number = entry_number + 1'b1;
                clear_record();
                if (entries_left == 0)
                    stopped = 1'b1;
            end
            else
            begin
                record_pos = POS_W'(p + 1);
            end
        endfunction

        function void cmp_field(string fname, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected word, kind expected none actual %0d entry %0d",
                         $time, got.kind, got.entry_index);
                errors++;
                return;
            end
            want = due_results.pop_front();
            cmp_field("kind", 32'(want.kind), 32'(got.kind));
            cmp_field("entry_index", 32'(want.entry_index), 32'(got.entry_index));
            cmp_field("name_char", 32'(want.name_char), 32'(got.name_char));
            cmp_field("name_pos", 32'(want.name_pos), 32'(got.name_pos));
            cmp_field("method", 32'(want.method), 32'(got.method));
            cmp_field("crc", want.crc, got.crc);
            cmp_field("comp_size", want.comp_size, got.comp_size);
            cmp_field("uncomp_size", want.uncomp_size, got.uncomp_size);
            cmp_field("local_offset", want.local_offset, got.local_offset);
            cmp_field("name_len", 32'(want.name_len), 32'(got.name_len));
            cmp_field("last_entry", 32'(want.last_entry), 32'(got.last_entry));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   tx_busy;
    bit   rx_busy;
    bit   hold_req;

    zip_dir_scoreboard sb;

    zcd_in_if  dir_if ();
    zcd_out_if res_if ();
    zcd_cfg_if cfg_if ();

    zip_central_directory_parser u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .dir    (dir_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic int pick_gap(bit busy);
        int roll;
        roll = $urandom_range(0, 99);
        if (!busy || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic first);
        int gap;
        gap = pick_gap(tx_busy);
        if (gap > 0)
        begin
            dir_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        dir_if.valid = 1'b1;
        dir_if.dir_byte = b;
        dir_if.first_byte = first;
        do @(posedge clk); while (!dir_if.ready);
        sb.parse_byte(b, first);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [WORD_W-1:0] value);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data = value;
        do @(posedge clk); while (!cfg_if.ready);
        sb.set_reg(idx, value);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // Bytes that give no word may still be in flight when the last word has come.
    task automatic settle();
        dir_if.valid = 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic add_record(ref logic [BYTE_W-1:0] stream [$]);
        logic [15:0] nlen;
        logic [15:0] elen;
        logic [15:0] clen;
        logic [15:0] meth;
        nlen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, 40))
                                            : 16'($urandom_range(0, 8));
        elen = 16'($urandom_range(0, 4));
        clen = 16'($urandom_range(0, 4));
        meth = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 20));
        for (int k = 0; k < HDR_LEN; k++)
        begin
            if (k == POS_METHOD)
                stream.push_back(meth[7:0]);
            else if (k == POS_METHOD + 1)
                stream.push_back(meth[15:8]);
            else if (k == POS_NAMELEN)
                stream.push_back(nlen[7:0]);
            else if (k == POS_NAMELEN + 1)
                stream.push_back(nlen[15:8]);
            else if (k == POS_EXTLEN)
                stream.push_back(elen[7:0]);
            else if (k == POS_EXTLEN + 1)
                stream.push_back(elen[15:8]);
            else if (k == POS_CMTLEN)
                stream.push_back(clen[7:0]);
            else if (k == POS_CMTLEN + 1)
                stream.push_back(clen[15:8]);
            else
                stream.push_back(8'($urandom));
        end
        repeat (nlen + elen + clen) stream.push_back(8'($urandom));
    endtask

    task automatic run_phase(input bit noisy, input bit squeeze);
        logic [BYTE_W-1:0]  stream [$];
        logic [COUNT_W-1:0] count_val;
        logic [WORD_W-1:0]  size_val;
        int                 nrec;
        int                 total;
        int                 sel;
        int                 restart_at;
        logic               first;
        tx_busy = !squeeze && ($urandom_range(0, 3) != 0);
        rx_busy = squeeze || ($urandom_range(0, 3) != 0);
        restart_at = -1;
        if (noisy)
        begin
            repeat ($urandom_range(30, 150)) stream.push_back(8'($urandom));
            count_val = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
            size_val = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 400);
        end
        else
        begin
            nrec = $urandom_range(1, 4);
            repeat (nrec) add_record(stream);
            total = stream.size();
            sel = $urandom_range(0, 9);
            if (sel <= 5)
                count_val = COUNT_W'(nrec);
            else if (sel == 6)
                count_val = COUNT_W'(nrec - 1);
            else if (sel == 7)
                count_val = COUNT_W'(nrec + 1);
            else if (sel == 8)
                count_val = 16'hFFFF;
            else
                count_val = '0;
            // The held-off receiver must see at least one word to fill the block.
            if (squeeze && count_val == '0)
                count_val = COUNT_W'(nrec);
            sel = $urandom_range(0, 11);
            if (sel <= 5)
                size_val = total;
            else if (sel == 6)
                size_val = total + $urandom_range(1, 100);
            else if (sel <= 8)
                size_val = total - $urandom_range(1, total);
            else if (sel == 9)
                size_val = MAX_DIR_BYTES;
            else if (sel == 10)
                size_val = MAX_DIR_BYTES + 1;
            else
                size_val = 32'hFFFF_FFFF;
            if ($urandom_range(0, 7) == 0)
                restart_at = $urandom_range(1, stream.size() - 1);
        end
        write_reg(REG_ENTRY_COUNT, WORD_W'(count_val));
        write_reg(REG_DIRECTORY_SIZE, size_val);
        if (squeeze)
            hold_req = 1'b1;
        for (int i = 0; i < stream.size(); i++)
        begin
            first = (i == 0) || (i == restart_at) || (noisy && $urandom_range(0, 39) == 0);
            send_byte(stream[i], first);
        end
        settle();
    endtask

    initial
    begin : result_ready_driver
        int gap;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                res_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = pick_gap(rx_busy);
            res_if.ready = (gap == 0);
            if (gap > 1)
                repeat (gap - 1) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.kind = res_if.kind;
            got.entry_index = res_if.entry_index;
            got.name_char = res_if.name_char;
            got.name_pos = res_if.name_pos;
            got.method = res_if.method;
            got.crc = res_if.crc;
            got.comp_size = res_if.comp_size;
            got.uncomp_size = res_if.uncomp_size;
            got.local_offset = res_if.local_offset;
            got.name_len = res_if.name_len;
            got.last_entry = res_if.last_entry;
            sb.check_result(got);
        end
    end

    initial
    begin : stimulus
        int phase_no;
        int waited;
        sb = new();
        rst_n = 1'b0;
        tx_busy = 1'b1;
        rx_busy = 1'b1;
        hold_req = 1'b0;
        dir_if.valid = 1'b0;
        dir_if.dir_byte = '0;
        dir_if.first_byte = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_ENTRY_COUNT;
        cfg_if.data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Out of reset the parser is stopped and ignores plain bytes.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        settle();

        write_reg(REG_ENTRY_COUNT, 32'd1);
        write_reg(REG_DIRECTORY_SIZE, 32'hFFFF_FFFF);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        settle();

        write_reg(REG_DIRECTORY_SIZE, MAX_DIR_BYTES + 1);
        send_byte(8'h3C, 1'b1);
        settle();

        // An empty directory stops without a word.
        write_reg(REG_ENTRY_COUNT, 32'd0);
        write_reg(REG_DIRECTORY_SIZE, MAX_DIR_BYTES);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h81, 1'b0);
        settle();

        // A zero-sized directory cuts the first record at its comment length.
        write_reg(REG_ENTRY_COUNT, 32'hFFFF);
        write_reg(REG_DIRECTORY_SIZE, 32'd0);
        for (int i = 0; i < POS_CMTLEN + 2; i++)
            send_byte(8'($urandom), i == 0);
        settle();

        phase_no = 0;
        while (sb.parsed_bytes < ITEM_GOAL)
        begin
            run_phase(($urandom_range(0, 4) == 0) && phase_no != 2, phase_no == 2);
            phase_no++;
        end

        dir_if.valid = 1'b0;
        waited = 0;
        while (sb.due_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.due_results.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, sb.due_results.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("%0t: timeout", $time);
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: zip_central_directory_parser.f
hdl/zcd_pkg.sv
hdl/zcd_in_if.sv
hdl/zcd_out_if.sv
hdl/zcd_cfg_if.sv
hdl/zcd_cfg_regs.sv
hdl/zcd_in_stage.sv
hdl/zcd_parse_core.sv
hdl/zcd_out_stage.sv
hdl/zip_central_directory_parser.sv
sim/testbench.sv
